>>> src/suk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package suk_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 31;
  localparam int GRP_W     = 22;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 4;
  localparam int GROUP_DIV = 1000;
  localparam int LO_W      = GRP_W + 10;
  localparam int HI_W      = LO_W + 1;

  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LIST_GRP = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST_ALL = 3'd4;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 4'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 4'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 4'd2;
  localparam logic [STAT_W-1:0] ST_DELETED   = 4'd3;
  localparam logic [STAT_W-1:0] ST_ABSENT    = 4'd4;
  localparam logic [STAT_W-1:0] ST_FOUND     = 4'd5;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 4'd6;
  localparam logic [STAT_W-1:0] ST_LISTED    = 4'd7;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PREP = 3'b010,
    S_SCAN = 3'b100
  } state_t;

endpackage

`default_nettype wire

>>> src/suk_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module suk_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/sorted_unique_key_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Every action is one forward pass over the held keys through a single RAM read port,
// one entry per cycle while the result channel does not stall; insert and delete shift
// entries during the same pass. Search, duplicate, full and absent results may end the
// pass early, before all held keys are read.
// in_stall is high from acceptance until the pass ends. Unknown actions give no result.
// Reset (synchronous, rst_n low) empties the table at once; stored keys stay undefined.

module sorted_unique_key_table
  import suk_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [KEY_W-1:0]  in_key,
  input  wire logic [GRP_W-1:0]  in_group,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [STAT_W-1:0]      out_status,
  output logic [KEY_W-1:0]       out_key_out,
  output logic [CNT_W-1:0]       out_entry_count,
  output logic                   out_last
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]   pr_idx_r, pr_idx_nxt;
  logic               dv_r, dv_nxt;
  logic               mode_r, mode_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [LO_W-1:0]    lo_r, lo_nxt;
  logic [HI_W-1:0]    hi_r, hi_nxt;
  logic [KEY_W-1:0]   carry_r, carry_nxt;
  logic [KEY_W-1:0]   pend_key_r, pend_key_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [KEY_W-1:0]   okey_r, okey_nxt;
  logic [CNT_W-1:0]   ocnt_r, ocnt_nxt;
  logic               olast_r, olast_nxt;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  logic [KEY_W-1:0]   ram_wdata, ram_rdata;

  logic               step_en, at_end, is_full, eq, gt, in_grp, match;
  logic               emit;
  logic [STAT_W-1:0]  em_status;
  logic [KEY_W-1:0]   em_key;
  logic [CNT_W-1:0]   em_count;
  logic               em_last;

  suk_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign step_en = !out_valid_r || !out_stall;
  assign at_end  = !dv_r && (rd_idx_r >= cnt_r);
  assign is_full = (cnt_r == CNT_W'(CAPACITY));
  assign eq      = (ram_rdata == key_r);
  assign gt      = (ram_rdata > key_r);
  assign in_grp  = ({{(HI_W-KEY_W){1'b0}}, ram_rdata} >= {1'b0, lo_r})
                && ({{(HI_W-KEY_W){1'b0}}, ram_rdata} < hi_r);
  assign match   = (act_r == ACT_LIST_ALL) || in_grp;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rd_idx_nxt   = rd_idx_r;
    pr_idx_nxt   = pr_idx_r;
    dv_nxt       = dv_r;
    mode_nxt     = mode_r;
    pend_nxt     = pend_r;
    act_nxt      = act_r;
    key_nxt      = key_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    carry_nxt    = carry_r;
    pend_key_nxt = pend_key_r;
    ram_we       = 1'b0;
    ram_waddr    = pr_idx_r;
    ram_wdata    = carry_r;
    ram_re       = 1'b0;
    emit         = 1'b0;
    em_status    = ST_EMPTY;
    em_key       = key_r;
    em_count     = cnt_r;
    em_last      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;
          key_nxt = in_key;
          lo_nxt  = LO_W'(in_group) * LO_W'(GROUP_DIV);
          if (in_action inside {ACT_INSERT, ACT_DELETE, ACT_SEARCH,
                                ACT_LIST_GRP, ACT_LIST_ALL}) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        hi_nxt     = {1'b0, lo_r} + HI_W'(GROUP_DIV);
        rd_idx_nxt = '0;
        dv_nxt     = 1'b0;
        mode_nxt   = 1'b0;
        pend_nxt   = 1'b0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (step_en) begin
          ram_re = (rd_idx_r < cnt_r);
          dv_nxt = ram_re;
          if (ram_re) begin
            rd_idx_nxt = rd_idx_r + CNT_W'(1);
            pr_idx_nxt = rd_idx_r[IDX_W-1:0];
          end
          if (dv_r) begin
            case (act_r)
              ACT_INSERT: begin
                if (mode_r) begin
                  // ripple: drop the carried key here, pick up the one displaced
                  ram_we    = 1'b1;
                  carry_nxt = ram_rdata;
                end else if (eq) begin
                  emit      = 1'b1;
                  em_status = ST_DUPLICATE;
                  state_nxt = S_IDLE;
                end else if (gt) begin
                  if (is_full) begin
                    emit      = 1'b1;
                    em_status = ST_FULL;
                    state_nxt = S_IDLE;
                  end else begin
                    ram_we    = 1'b1;
                    ram_wdata = key_r;
                    carry_nxt = ram_rdata;
                    mode_nxt  = 1'b1;
                  end
                end
              end
              ACT_DELETE: begin
                if (mode_r) begin
                  ram_we    = 1'b1;
                  ram_waddr = pr_idx_r - IDX_W'(1);
                  ram_wdata = ram_rdata;
                end else if (eq) begin
                  mode_nxt = 1'b1;
                end else if (gt) begin
                  emit      = 1'b1;
                  em_status = ST_ABSENT;
                  state_nxt = S_IDLE;
                end
              end
              ACT_SEARCH: begin
                if (eq || gt) begin
                  emit      = 1'b1;
                  em_status = eq ? ST_FOUND : ST_NOT_FOUND;
                  state_nxt = S_IDLE;
                end
              end
              default: begin
                // hold one match back so the final one can carry last
                if (match) begin
                  if (pend_r) begin
                    emit      = 1'b1;
                    em_status = ST_LISTED;
                    em_key    = pend_key_r;
                    em_last   = 1'b0;
                  end
                  pend_nxt     = 1'b1;
                  pend_key_nxt = ram_rdata;
                end
              end
            endcase
          end else if (at_end) begin
            state_nxt = S_IDLE;
            emit      = 1'b1;
            case (act_r)
              ACT_INSERT: begin
                if (!mode_r && is_full) begin
                  em_status = ST_FULL;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = cnt_r[IDX_W-1:0];
                  ram_wdata = mode_r ? carry_r : key_r;
                  cnt_nxt   = cnt_r + CNT_W'(1);
                  em_status = ST_INSERTED;
                  em_count  = cnt_r + CNT_W'(1);
                end
              end
              ACT_DELETE: begin
                if (mode_r) begin
                  cnt_nxt   = cnt_r - CNT_W'(1);
                  em_status = ST_DELETED;
                  em_count  = cnt_r - CNT_W'(1);
                end else begin
                  em_status = ST_ABSENT;
                end
              end
              ACT_SEARCH: begin
                em_status = ST_NOT_FOUND;
              end
              default: begin
                if (pend_r) begin
                  em_status = ST_LISTED;
                  em_key    = pend_key_r;
                end else begin
                  em_status = ST_EMPTY;
                  em_key    = '0;
                end
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    okey_nxt      = okey_r;
    ocnt_nxt      = ocnt_r;
    olast_nxt     = olast_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      status_nxt    = em_status;
      okey_nxt      = em_key;
      ocnt_nxt      = em_count;
      olast_nxt     = em_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      dv_r        <= 1'b0;
      mode_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      dv_r        <= dv_nxt;
      mode_r      <= mode_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pr_idx_r   <= pr_idx_nxt;
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    carry_r    <= carry_nxt;
    pend_key_r <= pend_key_nxt;
    status_r   <= status_nxt;
    okey_r     <= okey_nxt;
    ocnt_r     <= ocnt_nxt;
    olast_r    <= olast_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_key_out     = okey_r;
  assign out_entry_count = ocnt_r;
  assign out_last        = olast_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("held count beyond capacity");

  a_we_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN) && step_en)
    else $error("table write outside a scan step");

  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> out_valid_r && (out_entry_count == cnt_r)
      && (out_status == ST_INSERTED || out_status == ST_DELETED))
    else $error("held count changed without an insert or delete result");

  a_not_last_listed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !olast_r) |-> (status_r == ST_LISTED))
    else $error("non-final result that is not a listed key");

  a_pend_list: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && state_r == S_SCAN) |-> (act_r == ACT_LIST_GRP || act_r == ACT_LIST_ALL))
    else $error("pending listed key outside a listing");

endmodule

`default_nettype wire
